[sv/beq_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants for the bounded event queue
// no dependencies; the files that use this package refer to it by scoped name

package beq_pkg;

    localparam int DEPTH_DEF         = 16;
    localparam int PRIORITY_BITS_DEF = 8;
    localparam int PAYLOAD_BITS_DEF  = 32;

    localparam int STAT_W    = 32;
    localparam int CFG_IDX_W = 1;

    typedef enum logic [1:0] {
        ACT_ENQUEUE     = 2'd0,
        ACT_DEQUEUE     = 2'd1,
        ACT_PURGE       = 2'd2,
        ACT_CLEAR_STATS = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_FULL_DROP = 2'd1,
        STS_EMPTY     = 2'd2,
        STS_BAD_POL   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        POL_DROP_NEWEST = 2'd0,
        POL_DROP_LOWEST = 2'd1,
        POL_BLOCK       = 2'd2,
        POL_INVALID     = 2'd3
    } policy_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OVERFLOW_POLICY = 1'b0,
        REG_CAPACITY        = 1'b1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_SCAN,
        S_JUDGE,
        S_SHIFT,
        S_APPEND,
        S_DONE
    } state_t;

    // controls for the shared priority comparator
    typedef struct packed {
        logic load;
        logic step;
        logic judge;
    } seek_ctl_t;

endpackage

[sv/beq_store.sv]
`timescale 1ns / 1ps
// entry store: one write port, one read port with registered read data
// depends on nothing but its parameters

module beq_store #(
    parameter int DEPTH  = 16,
    parameter int DATA_W = 40
) (
    input  logic                       aclk,
    input  logic                       wr_en,
    input  logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  logic [DATA_W-1:0]          wr_data,
    input  logic [$clog2(DEPTH)-1:0]   rd_addr,
    output logic [DATA_W-1:0]          rd_data
);

    logic [DATA_W-1:0] store_mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= store_mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[sv/beq_seek.sv]
`timescale 1ns / 1ps
// shared priority comparator with running worst-entry register
// depends on beq_pkg for the control struct

module beq_seek #(
    parameter int PRIO_W = 8,
    parameter int ADDR_W = 4
) (
    input  logic              aclk,
    input  beq_pkg::seek_ctl_t ctl,
    input  logic [PRIO_W-1:0] rd_prio,
    input  logic [PRIO_W-1:0] item_prio,
    input  logic [ADDR_W-1:0] idx,
    output logic [ADDR_W-1:0] best_idx,
    output logic              gt
);

    logic [PRIO_W-1:0] best_prio_reg;
    logic [ADDR_W-1:0] best_idx_reg;
    logic [PRIO_W-1:0] operand;

    // strict compare keeps the oldest entry on a tie
    assign operand = ctl.judge ? item_prio : rd_prio;
    assign gt      = operand > best_prio_reg;

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            best_prio_reg <= rd_prio;
            best_idx_reg  <= '0;
        end else if (ctl.step && gt) begin
            best_prio_reg <= rd_prio;
            best_idx_reg  <= idx;
        end
    end

    assign best_idx  = best_idx_reg;

endmodule

[sv/beq_ctrl.sv]
`timescale 1ns / 1ps
// sequencer: ring pointers, fill level, statistics and the result register
// depends on beq_pkg; drives beq_store and beq_seek

module beq_ctrl #(
    parameter int DEPTH  = 16,
    parameter int PRIO_W = 8,
    parameter int PAY_W  = 32
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [1:0]                       s_action,
    input  logic [PRIO_W-1:0]                s_event_priority,
    input  logic [PAY_W-1:0]                 s_event_payload,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [1:0]                       m_status,
    output logic                             m_evicted,
    output logic [PRIO_W-1:0]                m_out_priority,
    output logic [PAY_W-1:0]                 m_out_payload,
    output logic [$clog2(DEPTH+1)-1:0]       m_depth_now,
    output logic [beq_pkg::STAT_W-1:0]       m_enqueued_total,
    output logic [beq_pkg::STAT_W-1:0]       m_dequeued_total,
    output logic [beq_pkg::STAT_W-1:0]       m_overflow_total,
    output logic [beq_pkg::STAT_W-1:0]       m_drop_total,
    output logic [$clog2(DEPTH+1)-1:0]       m_peak_depth,
    input  beq_pkg::policy_t                 policy,
    input  logic [$clog2(DEPTH+1)-1:0]       eff_cap,
    output logic                             mem_we,
    output logic [$clog2(DEPTH)-1:0]         mem_waddr,
    output logic [PRIO_W+PAY_W-1:0]          mem_wdata,
    output logic [$clog2(DEPTH)-1:0]         mem_raddr,
    input  logic [PRIO_W+PAY_W-1:0]          mem_rdata,
    output beq_pkg::seek_ctl_t               seek_ctl,
    output logic [$clog2(DEPTH)-1:0]         seek_idx,
    input  logic [$clog2(DEPTH)-1:0]         best_idx,
    input  logic                             seek_gt
);

    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH+1);
    localparam int ENTRY_W = PRIO_W + PAY_W;
    localparam int STAT_W  = beq_pkg::STAT_W;
    localparam logic [ADDR_W:0]   DEPTH_X  = (ADDR_W+1)'(DEPTH);
    localparam logic [ADDR_W-1:0] HEAD_MAX = ADDR_W'(DEPTH - 1);

    beq_pkg::state_t  state_reg, state_next;
    beq_pkg::action_t act_reg;
    logic [PRIO_W-1:0] prio_reg;
    logic [PAY_W-1:0]  pay_reg;

    logic [ADDR_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [ADDR_W-1:0] cnt_reg, cnt_next;
    logic [STAT_W-1:0] enq_reg, enq_next;
    logic [STAT_W-1:0] deq_reg, deq_next;
    logic [STAT_W-1:0] ovf_reg, ovf_next;
    logic [STAT_W-1:0] drop_reg, drop_next;
    logic [CNT_W-1:0]  wm_reg, wm_next;

    beq_pkg::status_t  res_status_reg, res_status_next;
    logic              res_evicted_reg, res_evicted_next;
    logic [PRIO_W-1:0] res_prio_reg, res_prio_next;
    logic [PAY_W-1:0]  res_pay_reg, res_pay_next;

    logic              m_valid_reg;
    beq_pkg::status_t  m_status_reg;
    logic              m_evicted_reg;
    logic [PRIO_W-1:0] m_prio_reg;
    logic [PAY_W-1:0]  m_pay_reg;
    logic [CNT_W-1:0]  m_depth_reg;
    logic [STAT_W-1:0] m_enq_reg, m_deq_reg, m_ovf_reg, m_drop_reg;
    logic [CNT_W-1:0]  m_peak_reg;

    logic              out_free;
    logic              out_load;
    logic              accept;
    logic              room;
    logic              lowest_path;
    logic [CNT_W-1:0]  fill_last;
    logic [CNT_W-1:0]  fill_inc;
    logic [CNT_W-1:0]  cnt_ext;
    logic [ADDR_W-1:0] rd_logical;
    logic [ADDR_W-1:0] head_inc;
    logic [PRIO_W-1:0] rd_prio;
    logic [PAY_W-1:0]  rd_pay;

    // ring position of a logical slot, oldest entry at logical zero
    function automatic logic [ADDR_W-1:0] phys(input logic [ADDR_W-1:0] base,
                                               input logic [ADDR_W-1:0] ofs);
        logic [ADDR_W:0] sum;
        sum = {1'b0, base} + {1'b0, ofs};
        if (sum >= DEPTH_X) begin
            sum = sum - DEPTH_X;
        end
        return sum[ADDR_W-1:0];
    endfunction

    assign out_free    = !m_valid_reg || m_ready;
    assign out_load    = (state_reg == beq_pkg::S_DONE) && out_free;
    assign s_ready     = (state_reg == beq_pkg::S_IDLE) || out_load;
    assign accept      = s_valid && s_ready;
    assign room        = fill_reg < eff_cap;
    assign lowest_path = (act_reg == beq_pkg::ACT_ENQUEUE) && !room &&
                         (policy == beq_pkg::POL_DROP_LOWEST);
    assign fill_last   = fill_reg - CNT_W'(1);
    assign fill_inc    = fill_reg + CNT_W'(1);
    assign cnt_ext     = CNT_W'(cnt_reg);
    assign head_inc    = (head_reg == HEAD_MAX) ? '0 : head_reg + ADDR_W'(1);
    assign rd_prio     = mem_rdata[ENTRY_W-1 -: PRIO_W];
    assign rd_pay      = mem_rdata[PAY_W-1:0];
    assign seek_idx    = cnt_reg;
    assign mem_raddr   = phys(head_reg, rd_logical);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            beq_pkg::S_IDLE: begin
                if (s_valid) begin
                    state_next = beq_pkg::S_DECIDE;
                end
            end
            beq_pkg::S_DECIDE: begin
                if (lowest_path) begin
                    state_next = (fill_reg > CNT_W'(1)) ? beq_pkg::S_SCAN : beq_pkg::S_JUDGE;
                end else begin
                    state_next = beq_pkg::S_DONE;
                end
            end
            beq_pkg::S_SCAN: begin
                if (cnt_ext == fill_last) begin
                    state_next = beq_pkg::S_JUDGE;
                end
            end
            beq_pkg::S_JUDGE: begin
                if (seek_gt) begin
                    state_next = beq_pkg::S_DONE;
                end else if (CNT_W'(best_idx) == fill_last) begin
                    state_next = beq_pkg::S_APPEND;
                end else begin
                    state_next = beq_pkg::S_SHIFT;
                end
            end
            beq_pkg::S_SHIFT: begin
                if (cnt_ext + CNT_W'(1) == fill_last) begin
                    state_next = beq_pkg::S_APPEND;
                end
            end
            beq_pkg::S_APPEND: begin
                state_next = beq_pkg::S_DONE;
            end
            beq_pkg::S_DONE: begin
                if (out_free) begin
                    state_next = s_valid ? beq_pkg::S_DECIDE : beq_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = beq_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and store controls
    always_comb begin
        head_next        = head_reg;
        fill_next        = fill_reg;
        cnt_next         = cnt_reg;
        enq_next         = enq_reg;
        deq_next         = deq_reg;
        ovf_next         = ovf_reg;
        drop_next        = drop_reg;
        wm_next          = wm_reg;
        res_status_next  = res_status_reg;
        res_evicted_next = res_evicted_reg;
        res_prio_next    = res_prio_reg;
        res_pay_next     = res_pay_reg;
        mem_we           = 1'b0;
        mem_waddr        = phys(head_reg, fill_reg[ADDR_W-1:0]);
        mem_wdata        = {prio_reg, pay_reg};
        rd_logical       = '0;
        seek_ctl         = '0;

        unique case (state_reg)
            beq_pkg::S_DECIDE: begin
                res_status_next  = beq_pkg::STS_OK;
                res_evicted_next = 1'b0;
                res_prio_next    = '0;
                res_pay_next     = '0;
                unique case (act_reg)
                    beq_pkg::ACT_ENQUEUE: begin
                        if (room) begin
                            mem_we    = 1'b1;
                            fill_next = fill_inc;
                            enq_next  = enq_reg + STAT_W'(1);
                            if (fill_inc > wm_reg) begin
                                wm_next = fill_inc;
                            end
                        end else begin
                            unique case (policy)
                                beq_pkg::POL_DROP_NEWEST, beq_pkg::POL_BLOCK: begin
                                    ovf_next        = ovf_reg + STAT_W'(1);
                                    res_status_next = beq_pkg::STS_FULL_DROP;
                                end
                                beq_pkg::POL_DROP_LOWEST: begin
                                    // head entry already read, start the scan
                                    seek_ctl.load = 1'b1;
                                    cnt_next      = ADDR_W'(1);
                                    rd_logical    = ADDR_W'(1);
                                end
                                beq_pkg::POL_INVALID: begin
                                    res_status_next = beq_pkg::STS_BAD_POL;
                                end
                                default: begin
                                    res_status_next = beq_pkg::STS_BAD_POL;
                                end
                            endcase
                        end
                    end
                    beq_pkg::ACT_DEQUEUE: begin
                        if (fill_reg == '0) begin
                            res_status_next = beq_pkg::STS_EMPTY;
                        end else begin
                            res_prio_next = rd_prio;
                            res_pay_next  = rd_pay;
                            head_next     = head_inc;
                            fill_next     = fill_last;
                            deq_next      = deq_reg + STAT_W'(1);
                        end
                    end
                    beq_pkg::ACT_PURGE: begin
                        drop_next = drop_reg + STAT_W'(fill_reg);
                        fill_next = '0;
                    end
                    beq_pkg::ACT_CLEAR_STATS: begin
                        enq_next  = '0;
                        deq_next  = '0;
                        ovf_next  = '0;
                        drop_next = '0;
                        wm_next   = '0;
                    end
                    default: begin
                        res_status_next = beq_pkg::STS_OK;
                    end
                endcase
            end
            beq_pkg::S_SCAN: begin
                seek_ctl.step = 1'b1;
                cnt_next      = cnt_reg + ADDR_W'(1);
                rd_logical    = cnt_reg + ADDR_W'(1);
            end
            beq_pkg::S_JUDGE: begin
                seek_ctl.judge = 1'b1;
                drop_next      = drop_reg + STAT_W'(1);
                cnt_next       = best_idx;
                rd_logical     = best_idx + ADDR_W'(1);
                if (seek_gt) begin
                    res_status_next = beq_pkg::STS_FULL_DROP;
                end else begin
                    res_evicted_next = 1'b1;
                end
            end
            beq_pkg::S_SHIFT: begin
                // close the gap: entry cnt+1 arrives and moves down one slot
                mem_we     = 1'b1;
                mem_waddr  = phys(head_reg, cnt_reg);
                mem_wdata  = mem_rdata;
                cnt_next   = cnt_reg + ADDR_W'(1);
                rd_logical = cnt_reg + ADDR_W'(2);
            end
            beq_pkg::S_APPEND: begin
                mem_we    = 1'b1;
                mem_waddr = phys(head_reg, fill_last[ADDR_W-1:0]);
                enq_next  = enq_reg + STAT_W'(1);
                if (fill_reg > wm_reg) begin
                    wm_next = fill_reg;
                end
            end
            beq_pkg::S_IDLE, beq_pkg::S_DONE: begin
                rd_logical = '0;
            end
            default: begin
                rd_logical = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= beq_pkg::S_IDLE;
            head_reg    <= '0;
            fill_reg    <= '0;
            enq_reg     <= '0;
            deq_reg     <= '0;
            ovf_reg     <= '0;
            drop_reg    <= '0;
            wm_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            fill_reg  <= fill_next;
            enq_reg   <= enq_next;
            deq_reg   <= deq_next;
            ovf_reg   <= ovf_next;
            drop_reg  <= drop_next;
            wm_reg    <= wm_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg         <= cnt_next;
        res_status_reg  <= res_status_next;
        res_evicted_reg <= res_evicted_next;
        res_prio_reg    <= res_prio_next;
        res_pay_reg     <= res_pay_next;
        if (accept) begin
            act_reg  <= beq_pkg::action_t'(s_action);
            prio_reg <= s_event_priority;
            pay_reg  <= s_event_payload;
        end
        if (out_load) begin
            m_status_reg  <= res_status_reg;
            m_evicted_reg <= res_evicted_reg;
            m_prio_reg    <= res_prio_reg;
            m_pay_reg     <= res_pay_reg;
            m_depth_reg   <= fill_reg;
            m_enq_reg     <= enq_reg;
            m_deq_reg     <= deq_reg;
            m_ovf_reg     <= ovf_reg;
            m_drop_reg    <= drop_reg;
            m_peak_reg    <= wm_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_evicted        = m_evicted_reg;
    assign m_out_priority   = m_prio_reg;
    assign m_out_payload    = m_pay_reg;
    assign m_depth_now      = m_depth_reg;
    assign m_enqueued_total = m_enq_reg;
    assign m_dequeued_total = m_deq_reg;
    assign m_overflow_total = m_ovf_reg;
    assign m_drop_total     = m_drop_reg;
    assign m_peak_depth     = m_peak_reg;

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CNT_W'(DEPTH))
        else $error("fill level above built depth");

    a_accept_decide: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg == beq_pkg::S_DECIDE)
        else $error("accepted beat not executed next cycle");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == beq_pkg::S_DONE)
        else $error("result loaded outside done state");

    a_evict_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_evicted_reg |-> m_status_reg == beq_pkg::STS_OK)
        else $error("eviction reported with failing status");

    a_shift_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == beq_pkg::S_SHIFT |-> cnt_ext + CNT_W'(1) < fill_reg)
        else $error("shift beyond held entries");

endmodule

[sv/bounded_event_queue_drop_lowest_unit.sv]
`timescale 1ns / 1ps
// top level of the bounded event queue with drop-lowest eviction
// depends on beq_pkg, beq_store, beq_seek and beq_ctrl
//
//  channel   ports                      direction  handshake
//  request   s_action/s_event_*         in         s_valid / s_ready
//  result    m_status .. m_peak_depth   out        m_valid / m_ready
//  config    cfg_index/cfg_data         in         cfg_we, no wait
//
// enqueue with room, dequeue, purge and statistics clear go from decide straight to done
// an enqueue on a full queue under drop-lowest first makes one store read per held
//   entry for the worst-entry scan, then the new event is rejected or the worst entry is
//   evicted; after an eviction each later entry is moved down one slot to close the gap
//   and the new event is appended; the single store read port makes these steps serial
// the store needs no clearing after reset; s_ready is low while a beat is in work
// a finished result waits in the output register; the next beat is taken meanwhile

module bounded_event_queue_drop_lowest_unit #(
    parameter int DEPTH         = beq_pkg::DEPTH_DEF,
    parameter int PRIORITY_BITS = beq_pkg::PRIORITY_BITS_DEF,
    parameter int PAYLOAD_BITS  = beq_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_we,
    input  logic [beq_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [(($clog2(DEPTH+1) > 2) ? $clog2(DEPTH+1) : 2)-1:0] cfg_data,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [1:0]                             s_action,
    input  logic [PRIORITY_BITS-1:0]               s_event_priority,
    input  logic [PAYLOAD_BITS-1:0]                s_event_payload,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [1:0]                             m_status,
    output logic                                   m_evicted,
    output logic [PRIORITY_BITS-1:0]               m_out_priority,
    output logic [PAYLOAD_BITS-1:0]                m_out_payload,
    output logic [$clog2(DEPTH+1)-1:0]             m_depth_now,
    output logic [beq_pkg::STAT_W-1:0]             m_enqueued_total,
    output logic [beq_pkg::STAT_W-1:0]             m_dequeued_total,
    output logic [beq_pkg::STAT_W-1:0]             m_overflow_total,
    output logic [beq_pkg::STAT_W-1:0]             m_drop_total,
    output logic [$clog2(DEPTH+1)-1:0]             m_peak_depth
);

    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH+1);
    localparam int ENTRY_W = PRIORITY_BITS + PAYLOAD_BITS;

    beq_pkg::policy_t   policy_reg;
    logic [CNT_W-1:0]   cap_reg;
    logic [CNT_W-1:0]   eff_cap;

    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [ENTRY_W-1:0] mem_wdata;
    logic [ADDR_W-1:0]  mem_raddr;
    logic [ENTRY_W-1:0] mem_rdata;

    beq_pkg::seek_ctl_t     seek_ctl;
    logic [ADDR_W-1:0]      seek_idx;
    logic [ADDR_W-1:0]      best_idx;
    logic                   seek_gt;

    // the comparator judges the held request priority against the worst entry
    logic [PRIORITY_BITS-1:0] s_event_priority_q;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            policy_reg <= beq_pkg::POL_DROP_NEWEST;
            cap_reg    <= CNT_W'(DEPTH);
        end else if (cfg_we) begin
            unique case (beq_pkg::cfg_reg_t'(cfg_index))
                beq_pkg::REG_OVERFLOW_POLICY: policy_reg <= beq_pkg::policy_t'(cfg_data[1:0]);
                beq_pkg::REG_CAPACITY:        cap_reg    <= cfg_data[CNT_W-1:0];
                default:                      cap_reg    <= cap_reg;
            endcase
        end
    end

    // zero acts as one, anything above the built depth acts as the depth
    always_comb begin
        if (cap_reg == '0) begin
            eff_cap = CNT_W'(1);
        end else if (cap_reg > CNT_W'(DEPTH)) begin
            eff_cap = CNT_W'(DEPTH);
        end else begin
            eff_cap = cap_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            s_event_priority_q <= s_event_priority;
        end
    end

    beq_store #(
        .DEPTH  (DEPTH),
        .DATA_W (ENTRY_W)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    beq_seek #(
        .PRIO_W (PRIORITY_BITS),
        .ADDR_W (ADDR_W)
    ) u_seek (
        .aclk      (aclk),
        .ctl       (seek_ctl),
        .rd_prio   (mem_rdata[ENTRY_W-1 -: PRIORITY_BITS]),
        .item_prio (s_event_priority_q),
        .idx       (seek_idx),
        .best_idx  (best_idx),
        .gt        (seek_gt)
    );

    beq_ctrl #(
        .DEPTH  (DEPTH),
        .PRIO_W (PRIORITY_BITS),
        .PAY_W  (PAYLOAD_BITS)
    ) u_ctrl (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_action         (s_action),
        .s_event_priority (s_event_priority),
        .s_event_payload  (s_event_payload),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_evicted        (m_evicted),
        .m_out_priority   (m_out_priority),
        .m_out_payload    (m_out_payload),
        .m_depth_now      (m_depth_now),
        .m_enqueued_total (m_enqueued_total),
        .m_dequeued_total (m_dequeued_total),
        .m_overflow_total (m_overflow_total),
        .m_drop_total     (m_drop_total),
        .m_peak_depth     (m_peak_depth),
        .policy           (policy_reg),
        .eff_cap          (eff_cap),
        .mem_we           (mem_we),
        .mem_waddr        (mem_waddr),
        .mem_wdata        (mem_wdata),
        .mem_raddr        (mem_raddr),
        .mem_rdata        (mem_rdata),
        .seek_ctl         (seek_ctl),
        .seek_idx         (seek_idx),
        .best_idx         (best_idx),
        .seek_gt          (seek_gt)
    );

    a_cap_range: assert property (@(posedge aclk) disable iff (!aresetn)
        eff_cap != '0 && eff_cap <= CNT_W'(DEPTH))
        else $error("effective capacity out of range");

    a_no_result_unused: assert property (@(posedge aclk) disable iff (!aresetn)
        seek_ctl.load |-> !seek_ctl.step && !seek_ctl.judge)
        else $error("comparator loaded and stepped together");

    a_one_write: assert property (@(posedge aclk) disable iff (!aresetn)
        seek_ctl.judge |-> !mem_we)
        else $error("store written while judging");

endmodule
